### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects signals named clk
// and rst in the scope where it is used. Synthesis builds define SYNTH and
// get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_IMPLIES(lbl, pre, post, msg)

`define ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### src/qrt_pkg.sv
`timescale 1ns / 1ps

package qrt_pkg;

  // Field and operand widths.
  localparam int COORD_W   = 32;
  localparam int QUAT_W    = 32;
  localparam int NUM_AXES  = 3;
  localparam int PROD_W    = 2 * QUAT_W;

  // Rotation matrix entries are quadratic in q, doubled: 66 bits signed.
  localparam int MAT_W     = PROD_W + 2;
  localparam int SPLIT_W   = 32;
  localparam int MHI_W     = MAT_W - SPLIT_W;
  localparam int LO_PROD_W = SPLIT_W + 1 + COORD_W;
  localparam int HI_PROD_W = MHI_W + COORD_W;
  localparam int LO_SUM_W  = LO_PROD_W + 2;
  localparam int HI_SUM_W  = HI_PROD_W + 2;
  localparam int ACC_W     = 100;

  localparam int QUAT_FRAC_BITS_DEF = 30;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_QUAT_W  = 3'd1,
    REG_QUAT_X  = 3'd2,
    REG_QUAT_Y  = 3'd3,
    REG_QUAT_Z  = 3'd4,
    REG_PIVOT_X = 3'd5,
    REG_PIVOT_Y = 3'd6,
    REG_PIVOT_Z = 3'd7
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [QUAT_W-1:0]    quat_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [MAT_W-1:0]     mat_t;
  typedef logic signed [LO_PROD_W-1:0] lo_prod_t;
  typedef logic signed [HI_PROD_W-1:0] hi_prod_t;
  typedef logic signed [LO_SUM_W-1:0]  lo_sum_t;
  typedef logic signed [HI_SUM_W-1:0]  hi_sum_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

endpackage

### src/quaternion_rotate_translate.sv
`timescale 1ns / 1ps
// Rotates one vertex per beat by the quaternion q, as the vector part of
// q*v*conj(q) with q taken as written (a non-unit q also scales by |q|^2),
// then adds the pivot and saturates each component to signed 32 bits; with
// the transform disabled the vertex comes back unchanged and saturated is 0.
// Coordinates and pivot are signed Q16.16, quaternion parts signed Q2.30
// (fraction bits set by QUAT_FRAC_BITS). The block is a six-stage pipeline
// that takes a new vertex every cycle while the output is taken: quaternion
// pair products, rotation matrix, split 34x32 / 33x32 partial products,
// per-axis partial sums, the exact 100-bit accumulation, and a final stage
// that drops the quaternion fraction bits (truncating toward minus
// infinity), adds the pivot and saturates. Each stage only holds while the
// one after it is full and stalled, so bubbles close up and throughput is
// one beat per cycle while the output is taken. The quaternion and enable
// are sampled when a vertex enters and the pivot when it leaves, so the user
// must write configuration only while the pipeline is empty; the block
// itself does not enforce this.
`include "assert_macros.svh"

module quaternion_rotate_translate
  import qrt_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_W-1:0]            cfg_data,
  // Input vertex stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [NUM_AXES*COORD_W-1:0]   s_axis_tdata,  // point_x, point_y, point_z
  // Output vertex stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [NUM_AXES*COORD_W-1:0]   m_axis_tdata,  // world_x, world_y, world_z
  output logic                          m_axis_tuser   // saturated
);

  localparam int NST   = 5;
  localparam int SHIFT = 2 * QUAT_FRAC_BITS;
  localparam logic [QUAT_W-1:0] QW_RESET = QUAT_W'(1) << QUAT_FRAC_BITS;

  // Configuration registers.
  logic   enable;
  quat_t  qw, qx, qy, qz;
  coord_t pivot [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      qw     <= quat_t'(QW_RESET);
      qx     <= '0;
      qy     <= '0;
      qz     <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        pivot[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:  enable   <= cfg_data[0];
        REG_QUAT_W:  qw       <= quat_t'(cfg_data);
        REG_QUAT_X:  qx       <= quat_t'(cfg_data);
        REG_QUAT_Y:  qy       <= quat_t'(cfg_data);
        REG_QUAT_Z:  qz       <= quat_t'(cfg_data);
        REG_PIVOT_X: pivot[0] <= coord_t'(cfg_data);
        REG_PIVOT_Y: pivot[1] <= coord_t'(cfg_data);
        REG_PIVOT_Z: pivot[2] <= coord_t'(cfg_data);
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its successor loads.
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;
  logic           adv_out;

  always_comb begin
    adv_out      = !m_axis_tvalid || m_axis_tready;
    adv[NST-1]   = !vld[NST-1] || adv_out;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  coord_t point_in [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      point_in[i] = coord_t'(s_axis_tdata[i*COORD_W +: COORD_W]);
    end
  end

  // Stage 0: the ten quaternion pair products.
  coord_t point0 [NUM_AXES];
  logic   en0;
  prod_t  p_ww, p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      point0 <= point_in;
      en0    <= enable;
      p_ww   <= qw * qw;
      p_xx   <= qx * qx;
      p_yy   <= qy * qy;
      p_zz   <= qz * qz;
      p_xy   <= qx * qy;
      p_xz   <= qx * qz;
      p_yz   <= qy * qz;
      p_wx   <= qw * qx;
      p_wy   <= qw * qy;
      p_wz   <= qw * qz;
    end
  end

  // Stage 1: rotation matrix. Expanding the vector part of q*v*conj(q)
  // gives these entries exactly, scaled by two to the 2*QUAT_FRAC_BITS.
  coord_t point1 [NUM_AXES];
  logic   en1;
  mat_t   mat1 [NUM_AXES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      point1     <= point0;
      en1        <= en0;
      mat1[0][0] <= mat_t'(p_ww) + mat_t'(p_xx) - mat_t'(p_yy) - mat_t'(p_zz);
      mat1[0][1] <= (mat_t'(p_xy) - mat_t'(p_wz)) <<< 1;
      mat1[0][2] <= (mat_t'(p_xz) + mat_t'(p_wy)) <<< 1;
      mat1[1][0] <= (mat_t'(p_xy) + mat_t'(p_wz)) <<< 1;
      mat1[1][1] <= mat_t'(p_ww) - mat_t'(p_xx) + mat_t'(p_yy) - mat_t'(p_zz);
      mat1[1][2] <= (mat_t'(p_yz) - mat_t'(p_wx)) <<< 1;
      mat1[2][0] <= (mat_t'(p_xz) - mat_t'(p_wy)) <<< 1;
      mat1[2][1] <= (mat_t'(p_yz) + mat_t'(p_wx)) <<< 1;
      mat1[2][2] <= mat_t'(p_ww) - mat_t'(p_xx) - mat_t'(p_yy) + mat_t'(p_zz);
    end
  end

  // Stage 2: each 66-bit entry times the coordinate, as an unsigned low
  // half and a signed high half.
  coord_t   point2 [NUM_AXES];
  logic     en2;
  lo_prod_t lo2 [NUM_AXES][NUM_AXES];
  hi_prod_t hi2 [NUM_AXES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      point2 <= point1;
      en2    <= en1;
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          lo2[i][j] <= $signed({1'b0, mat1[i][j][SPLIT_W-1:0]}) * point1[j];
          hi2[i][j] <= $signed(mat1[i][j][MAT_W-1:SPLIT_W]) * point1[j];
        end
      end
    end
  end

  // Stage 3: partial sums per axis.
  coord_t  point3 [NUM_AXES];
  logic    en3;
  lo_sum_t lo_sum3 [NUM_AXES];
  hi_sum_t hi_sum3 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      point3 <= point2;
      en3    <= en2;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo_sum3[i] <= lo_sum_t'(lo2[i][0]) + lo_sum_t'(lo2[i][1]) + lo_sum_t'(lo2[i][2]);
        hi_sum3[i] <= hi_sum_t'(hi2[i][0]) + hi_sum_t'(hi2[i][1]) + hi_sum_t'(hi2[i][2]);
      end
    end
  end

  // Stage 4: exact accumulation of the rotated component.
  coord_t point4 [NUM_AXES];
  logic   en4;
  acc_t   acc4 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      point4 <= point3;
      en4    <= en3;
      for (int i = 0; i < NUM_AXES; i++) begin
        acc4[i] <= (acc_t'(hi_sum3[i]) <<< SPLIT_W) + acc_t'(lo_sum3[i]);
      end
    end
  end

  // Output stage: drop the quaternion fraction, add the pivot, saturate; pass-through when disabled.
  coord_t world_next [NUM_AXES];
  logic   sat_next;
  coord_t world [NUM_AXES];
  logic   out_en;

  always_comb begin
    acc_t shifted;
    acc_t total;
    logic fits;
    sat_next = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      shifted = acc4[i] >>> SHIFT;
      total   = shifted + acc_t'(pivot[i]);
      fits    = (&total[ACC_W-1:COORD_W-1]) || !(|total[ACC_W-1:COORD_W-1]);
      if (!en4) begin
        world_next[i] = point4[i];
      end else if (fits) begin
        world_next[i] = total[COORD_W-1:0];
      end else begin
        world_next[i] = total[ACC_W-1] ? COORD_MIN : COORD_MAX;
        sat_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_axis_tvalid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      world        <= world_next;
      out_en       <= en4;
      m_axis_tuser <= sat_next;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      m_axis_tdata[i*COORD_W +: COORD_W] = world[i];
    end
  end

  `ASSERT_NEXT(a_accept_enters_pipe, s_axis_tvalid && s_axis_tready, vld[0], "accepted beat did not enter the pipeline")
  `ASSERT_NEXT(a_stalled_stage_holds, vld[NST-1] && !adv[NST-1], vld[NST-1], "stalled stage lost its vertex")
  `ASSERT_IMPLIES(a_bypass_no_clip, m_axis_tvalid && !out_en, !m_axis_tuser, "pass-through beat flagged as saturated")
  `ASSERT_IMPLIES(a_clip_is_extreme, m_axis_tvalid && m_axis_tuser, world[0] == COORD_MAX || world[0] == COORD_MIN || world[1] == COORD_MAX || world[1] == COORD_MIN || world[2] == COORD_MAX || world[2] == COORD_MIN, "saturated set with no clipped component")
  `ASSERT_CLK(a_ready_when_out_free, !m_axis_tvalid |-> s_axis_tready, "input stalled while output is empty")

endmodule

### verif/quaternion_rotate_translate_test.sv
`timescale 1ns / 1ps

module quaternion_rotate_translate_test;
  import qrt_pkg::*;

  // The accumulator keeps 2*QUAT_FRAC_BITS + COORD_FRAC_BITS fraction bits.
  // Dropping the quaternion part leaves Q16.16.
  localparam int DROP_BITS   = 2 * QUAT_FRAC_BITS_DEF;
  localparam int PIPE_DEPTH  = 6;
  localparam int SEG_ITEMS   = 200;
  localparam int NUM_SEGS    = 9;
  localparam int HOLD_CYCLES = 300;
  // The longest quiet stretch of a correct run is the receiver hold-off plus
  // the pipeline. The watchdog allows ten times the hold-off alone.
  localparam int QUIET_LIMIT = 3000;

  localparam quat_t  Q_ONE      = quat_t'(32'sd1 <<< QUAT_FRAC_BITS_DEF);
  // cos(45 deg) in Q2.30: qw = qz = this gives a quarter turn about z.
  localparam quat_t  Q_HALF_RT2 = 32'sd759250125;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic   sat;
    coord_t wz;
    coord_t wy;
    coord_t wx;
  } world_t;

  // Holds a private copy of the register file and the world-space vertices
  // that are still owed by the pipeline, oldest first.
  class world_scoreboard;
    logic         enable;
    quat_t        qw, qx, qy, qz;
    coord_t       px, py, pz;
    world_t       expected_world[$];
    int           mismatches;

    function new();
      enable     = 1'b0;
      qw         = Q_ONE;
      qx         = '0;
      qy         = '0;
      qz         = '0;
      px         = '0;
      py         = '0;
      pz         = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [COORD_W-1:0] data);
      case (idx)
        REG_ENABLE:  enable = data[0];
        REG_QUAT_W:  qw = data;
        REG_QUAT_X:  qx = data;
        REG_QUAT_Y:  qy = data;
        REG_QUAT_Z:  qz = data;
        REG_PIVOT_X: px = data;
        REG_PIVOT_Y: py = data;
        REG_PIVOT_Z: pz = data;
        default: ;
      endcase
    endfunction

    // Vector part of q*v*conj(q), written as
    // (w^2 - u.u) v + 2 (u.v) u + 2 w (u x v). Every term fits well inside
    // 128 bits, so the sum is exact before the truncating shift.
    function world_t rotate_translate(coord_t x, coord_t y, coord_t z);
      wide_t  w, sc, dot, acc;
      wide_t  v[3], u[3], p[3], cr[3];
      coord_t res[3];
      logic   clip;
      world_t r;
      if (!enable) begin
        r.wx  = x;
        r.wy  = y;
        r.wz  = z;
        r.sat = 1'b0;
        return r;
      end
      w = qw;
      v[0] = x;  v[1] = y;  v[2] = z;
      u[0] = qx; u[1] = qy; u[2] = qz;
      p[0] = px; p[1] = py; p[2] = pz;
      sc  = w * w - u[0] * u[0] - u[1] * u[1] - u[2] * u[2];
      dot = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      cr[0] = u[1] * v[2] - u[2] * v[1];
      cr[1] = u[2] * v[0] - u[0] * v[2];
      cr[2] = u[0] * v[1] - u[1] * v[0];
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = sc * v[i] + 2 * dot * u[i] + 2 * w * cr[i];
        acc = (acc >>> DROP_BITS) + p[i];
        if (acc[127:COORD_W-1] != {(128-COORD_W+1){acc[127]}}) begin
          clip   = 1'b1;
          res[i] = acc[127] ? COORD_MIN : COORD_MAX;
        end else begin
          res[i] = acc[COORD_W-1:0];
        end
      end
      r.wx  = res[0];
      r.wy  = res[1];
      r.wz  = res[2];
      r.sat = clip;
      return r;
    endfunction

    function void note_vertex(coord_t x, coord_t y, coord_t z);
      expected_world.push_back(rotate_translate(x, y, z));
    endfunction

    function int pending();
      return expected_world.size();
    endfunction

    // One line per mismatch, and every one is counted.
    task report(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      mismatches++;
      $display("[%0t] %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(logic [NUM_AXES*COORD_W-1:0] data, logic sat);
      world_t want;
      if (expected_world.size() == 0) begin
        report("unexpected output beat", data[COORD_W-1:0], '0);
        return;
      end
      want = expected_world.pop_front();
      if (data[COORD_W-1:0] !== want.wx)
        report("world_x", data[COORD_W-1:0], want.wx);
      if (data[2*COORD_W-1:COORD_W] !== want.wy)
        report("world_y", data[2*COORD_W-1:COORD_W], want.wy);
      if (data[3*COORD_W-1:2*COORD_W] !== want.wz)
        report("world_z", data[3*COORD_W-1:2*COORD_W], want.wz);
      if (sat !== want.sat)
        report("saturated", {{(COORD_W-1){1'b0}}, sat}, {{(COORD_W-1){1'b0}}, want.sat});
    endtask
  endclass

  // Every input of the block is known from time zero.
  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        cfg_wr_en     = 1'b0;
  cfg_reg_t                    cfg_index     = REG_ENABLE;
  logic [COORD_W-1:0]          cfg_data      = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [NUM_AXES*COORD_W-1:0] s_axis_tdata  = '0;  // point_x, point_y, point_z
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [NUM_AXES*COORD_W-1:0] m_axis_tdata;        // world_x, world_y, world_z
  logic                        m_axis_tuser;        // saturated

  world_scoreboard sb = new();

  // Percent of cycles in which each side idles, and the remaining length of
  // a forced receiver hold-off.
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int quiet     = 0;

  quaternion_rotate_translate dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: ready changes on the falling edge only. A hold-off request
  // overrides the random idling until its cycle count runs out.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Output beats are checked at the rising edge where they are taken.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: any beat on either stream, or a register write, counts as
  // progress. A long quiet stretch means the block has hung.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offers one vertex beat, idling first at the sender's current rate. Valid
  // is left high after the beat is taken so back-to-back beats need no
  // second assignment in the same step. Returns at a falling edge.
  task automatic send_vertex(coord_t x, coord_t y, coord_t z);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_vertex(x, y, z);
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed vertex has come out, then
  // waits past the pipeline depth as well so the pipeline is surely empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Write enable stays high across consecutive writes; the caller lowers it.
  task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // The quaternion is sampled on entry and the pivot on exit, so the whole
  // register set is only rewritten with the pipeline empty.
  task automatic load_config(logic en, quat_t w, quat_t x, quat_t y, quat_t z,
                             coord_t pvx, coord_t pvy, coord_t pvz);
    drain();
    write_reg(REG_ENABLE,  {{(COORD_W-1){1'b0}}, en});
    write_reg(REG_QUAT_W,  w);
    write_reg(REG_QUAT_X,  x);
    write_reg(REG_QUAT_Y,  y);
    write_reg(REG_QUAT_Z,  z);
    write_reg(REG_PIVOT_X, pvx);
    write_reg(REG_PIVOT_Y, pvy);
    write_reg(REG_PIVOT_Z, pvz);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of extremes, full-range patterns and values shrunk by a random
  // arithmetic shift. Small values keep most rotations clear of saturation;
  // the full-range ones make every bit toggle and drive overflow.
  function automatic logic signed [31:0] rand_val(int max_shift);
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = COORD_MAX;
          1:       v = COORD_MIN;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: begin
        v = $urandom;
        v = v >>> $urandom_range(1, max_shift);
      end
    endcase
    return v;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The sender idles lightly and the receiver heavily.
    send_idle = 24;
    recv_idle = 87;

    // Out of reset the transform is off: extremes pass straight through.
    send_vertex(COORD_MAX, COORD_MIN, '0);
    send_vertex(-1, 1, 32'sh0001_0000);

    // Identity quaternion with the transform on: vertices come back as-is.
    load_config(1'b1, Q_ONE, '0, '0, '0, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MIN, -1);
    send_vertex('0, 1, 32'sh0003_2000);

    // A non-unit quaternion scales by |q|^2, here close to four, so large
    // vertices overflow in both directions.
    load_config(1'b1, COORD_MAX, '0, '0, '0, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MIN, 32'sh0000_8000);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh1000_0000);

    // Quarter turn about z with a unit quaternion, plus a pivot.
    load_config(1'b1, Q_HALF_RT2, '0, '0, Q_HALF_RT2,
                32'sh0002_0000, -32'sh0001_0000, 32'sh0000_4000);
    send_vertex(32'sh0001_0000, '0, 32'sh0005_0000);
    send_vertex(-32'sh0010_0000, 32'sh0000_0001, -1);

    // Every quaternion part at its most negative value.
    load_config(1'b1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(1, -1, 32'sh0000_0100);

    // Every quaternion part at its most positive value, pivots at minimum.
    load_config(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(32'sh0000_0010, -32'sh0000_0020, 32'sh0000_0030);

    // Pivot extremes under the identity rotation: x overflows upward, y
    // downward, z lands exactly one below the top without clipping.
    load_config(1'b1, Q_ONE, '0, '0, '0, COORD_MAX, COORD_MIN, COORD_MAX);
    send_vertex(COORD_MAX, COORD_MIN, -1);
    send_vertex('0, '0, '0);

    // Transform off with everything else loaded: the pass-through must
    // ignore the quaternion and the pivot and never flag saturation.
    load_config(1'b0, COORD_MIN, COORD_MAX, 32'sh1234_5678, -32'sh0765_4321,
                COORD_MAX, COORD_MIN, COORD_MAX);
    send_vertex(COORD_MAX, COORD_MIN, 32'sh7FFF_0000);

    // Random part. Segments 0-2 throttle the receiver, 3-5 the sender, 6-8
    // run flat out. Every third segment has the transform off.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg < 3) begin
        send_idle = 24;
        recv_idle = 87;
      end else if (seg < 6) begin
        send_idle = 87;
        recv_idle = 24;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_config(seg % 3 != 2, rand_val(4), rand_val(4), rand_val(4), rand_val(4),
                  rand_val(23), rand_val(23), rand_val(23));

      // With the sender flat out, hold the receiver off for a long stretch
      // so the pipeline fills and input ready drops.
      if (seg == 6)
        hold_left = HOLD_CYCLES;

      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Once mid-stream, stop sending until everything has come back.
        if (seg == 7 && n == SEG_ITEMS / 2)
          drain();
        send_vertex(rand_val(23), rand_val(23), rand_val(23));
      end
    end

    drain();
    repeat (2 * PIPE_DEPTH) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
